>>> hdl/hktt_pkg.sv
package hktt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int PTR_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 32;
   localparam int SLOT_W      = 7;

   // slot code for "no slot": the depth, masked to the slot width
   localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(TABLE_DEPTH);

   typedef enum logic [1:0] {
      CMD_PRESS     = 2'd0,
      CMD_RELEASE   = 2'd1,
      CMD_CHECK     = 2'd2,
      CMD_CHECK_REL = 2'd3
   } cmd_type;

   // one table entry as stored in the RAM
   typedef struct packed {
      logic [KEY_W-1:0] code;
      logic [KEY_W-1:0] alt;
      logic [KEY_W-1:0] sym;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // verdict of one entry against the current query
   typedef struct packed {
      logic             hit;       // entry stops the search
      logic             ins_free;  // entry can take a new key
      logic [KEY_W-1:0] ins_alt;   // alternate to keep when inserting here
      logic [KEY_W-1:0] last_alt;  // alternate copied out on release
   } match_type;

endpackage

>>> hdl/held_key_tracking_table_top.sv
// Held-key table: tracks the keys that are currently pressed.
//
// Request channel (req_*): one beat is one command. req_tuser carries the
// command (press, release, check held, check last released), req_tdata the
// key symbol and key code. Response channel (rsp_*): exactly one beat per
// request with the found flag, the slot index (table depth means none) and
// the released-match flag.
//
// Every table command scans the slots from 0 upward through a single RAM
// read port, one slot a cycle, and stops at the first match or at the
// last slot. A check of the last released key and a press with a zero
// code skip the scan. One request is in work at a time; req_tready is
// high while the block is idle, also while an earlier response still
// waits in the output register.
//
// Reset clears all slot valid bits at once (a slot that is not valid reads
// as all zero) and the last-released registers; the table is usable in the
// first cycle after reset. When the receiver stalls, the scan freezes on
// its final slot until the output register frees up; nothing is dropped.
module held_key_tracking_table_top (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] key_sym, [63:32] phys_code
   input  logic [1:0]  req_tuser,   // [1:0] command
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] found, [7:1] slot, [8] released_match, rest 0
);

   import hktt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff;
   logic [KEY_W-1:0] sym_ff;
   logic [KEY_W-1:0] code_ff;
   logic             trivial_ff;

   logic [PTR_W-1:0] scan_ptr_ff;
   logic             eval_vld_ff;
   logic [IDX_W-1:0] eval_idx_ff;
   logic             ent_vld_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;

   logic             free_fnd_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic [KEY_W-1:0] free_alt_ff;

   logic [KEY_W-1:0] last_sym_ff;
   logic [KEY_W-1:0] last_alt_ff;

   logic              out_vld_ff;
   logic              out_found_ff;
   logic [SLOT_W-1:0] out_slot_ff;
   logic              out_rel_ff;

   logic             accept;
   logic             out_free;
   logic             in_scan;
   logic             is_last;
   logic             finish;
   logic             stall;
   logic             done;
   logic             rd_en;
   logic [ENTRY_W-1:0] rd_data;
   entry_type        entry;
   match_type        verdict;
   logic             cur_free;
   logic             ins_ok;
   logic [IDX_W-1:0] ins_idx;
   logic [KEY_W-1:0] ins_alt;
   logic             wr_en;
   entry_type        wr_entry;
   logic             rel_clr;
   logic             res_found;
   logic [SLOT_W-1:0] res_slot;
   logic             res_rel;
   cmd_type          req_cmd;

   assign req_cmd    = cmd_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_vld_ff || rsp_tready;
   assign in_scan    = (state_ff == ST_SCAN);

   // a slot that was never written or was released reads as all zero
   assign entry = ent_vld_ff ? entry_type'(rd_data) : '0;

   hktt_match u_match (
      .cmd       (cmd_ff),
      .key_sym   (sym_ff),
      .phys_code (code_ff),
      .entry     (entry),
      .result    (verdict)
   );

   assign is_last = (eval_idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign finish  = in_scan && (trivial_ff || (eval_vld_ff && (verdict.hit || is_last)));
   assign stall   = finish && !out_free;
   assign done    = finish && out_free;
   assign rd_en   = in_scan && !trivial_ff && !stall && (scan_ptr_ff < PTR_W'(TABLE_DEPTH));

   // first insertion candidate: one recorded earlier, else the slot in hand
   assign cur_free = eval_vld_ff && verdict.ins_free;
   assign ins_ok   = free_fnd_ff || cur_free;
   assign ins_idx  = free_fnd_ff ? free_idx_ff : eval_idx_ff;
   assign ins_alt  = free_fnd_ff ? free_alt_ff : verdict.ins_alt;

   assign wr_en = done && !trivial_ff && (cmd_ff == CMD_PRESS) && !verdict.hit && ins_ok;
   assign rel_clr = done && !trivial_ff && (cmd_ff == CMD_RELEASE) && verdict.hit;

   always_comb begin
      wr_entry.sym  = sym_ff;
      wr_entry.alt  = ins_alt;
      wr_entry.code = code_ff;
   end

   hktt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ins_idx),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (scan_ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // response for the command that finishes this cycle
   always_comb begin
      res_found = 1'b0;
      res_slot  = SLOT_NONE;
      res_rel   = 1'b0;
      if (trivial_ff) begin
         res_rel = (cmd_ff == CMD_CHECK_REL) && (sym_ff != '0)
                   && ((last_sym_ff == sym_ff) || (last_alt_ff == sym_ff));
      end else if (verdict.hit) begin
         res_found = 1'b1;
         res_slot  = SLOT_W'(eval_idx_ff);
      end else if ((cmd_ff == CMD_PRESS) && ins_ok) begin
         res_found = 1'b1;
         res_slot  = SLOT_W'(ins_idx);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         eval_vld_ff <= 1'b0;
         free_fnd_ff <= 1'b0;
         valid_ff    <= '0;
         out_vld_ff  <= 1'b0;
         last_sym_ff <= '0;
         last_alt_ff <= '0;
         scan_ptr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            scan_ptr_ff <= '0;
            eval_vld_ff <= 1'b0;
            free_fnd_ff <= 1'b0;
         end else if (done) begin
            eval_vld_ff <= 1'b0;
         end else if (in_scan && !stall) begin
            // advance the scan: issue one read, evaluate the one before
            eval_vld_ff <= rd_en;
            if (rd_en) begin
               scan_ptr_ff <= scan_ptr_ff + PTR_W'(1);
            end
            if (cur_free && !free_fnd_ff) begin
               free_fnd_ff <= 1'b1;
            end
         end
         if (wr_en) begin
            valid_ff[ins_idx] <= 1'b1;
         end
         if (rel_clr) begin
            valid_ff[eval_idx_ff] <= 1'b0;
            last_sym_ff           <= entry.sym;
            last_alt_ff           <= verdict.last_alt;
         end
         if (done) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_cmd;
         sym_ff     <= req_tdata[31:0];
         code_ff    <= req_tdata[63:32];
         trivial_ff <= (req_cmd == CMD_CHECK_REL)
                       || ((req_cmd == CMD_PRESS) && (req_tdata[63:32] == '0));
      end
      if (rd_en) begin
         eval_idx_ff <= scan_ptr_ff[IDX_W-1:0];
         ent_vld_ff  <= valid_ff[scan_ptr_ff[IDX_W-1:0]];
      end
      if (in_scan && !stall && !done && cur_free && !free_fnd_ff) begin
         free_idx_ff <= eval_idx_ff;
         free_alt_ff <= verdict.ins_alt;
      end
      if (done) begin
         out_found_ff <= res_found;
         out_slot_ff  <= res_slot;
         out_rel_ff   <= res_rel;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_rel_ff, out_slot_ff, out_found_ff};

   // a finishing command never overwrites an undelivered response
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> (!out_vld_ff || rsp_tready))
      else $error("response register overwritten");

   // insert and release never touch the table in the same cycle
   a_one_update: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rel_clr))
      else $error("insert and release in one cycle");

   // nothing is being evaluated while idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !eval_vld_ff)
      else $error("evaluation pending while idle");

   // the scan pointer never runs past the table
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      scan_ptr_ff <= PTR_W'(TABLE_DEPTH))
      else $error("scan pointer out of range");

   // a stalled finish holds the scan position
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(scan_ptr_ff) && $stable(eval_idx_ff))
      else $error("scan moved during stall");

endmodule

>>> hdl/hktt_ram.sv
module hktt_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold the last read word while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/hktt_match.sv
module hktt_match (
   input  hktt_pkg::cmd_type                cmd,
   input  logic [hktt_pkg::KEY_W-1:0]       key_sym,
   input  logic [hktt_pkg::KEY_W-1:0]       phys_code,
   input  hktt_pkg::entry_type              entry,
   output hktt_pkg::match_type              result
);

   import hktt_pkg::*;

   logic sym_zero;
   logic code_zero;
   logic rule_free;
   logic rule_sym;
   logic rule_upd;
   logic rule_code;

   assign sym_zero  = (key_sym == '0);
   assign code_zero = (phys_code == '0);

   // rules in priority order: free slot, symbol, code with update, code only
   assign rule_free = sym_zero && code_zero && (entry.sym == '0);
   assign rule_sym  = !sym_zero && ((entry.sym == key_sym) || (entry.alt == key_sym));
   assign rule_upd  = (cmd == CMD_RELEASE) && (entry.code == phys_code);
   assign rule_code = sym_zero && !code_zero && (entry.code == phys_code);

   always_comb begin
      result.hit      = rule_free || rule_sym || rule_upd || rule_code;
      // a slot can take a new key when its symbol or its code is zero
      result.ins_free = (entry.sym == '0) || (entry.code == '0);
      result.ins_alt  = (entry.sym == '0) ? entry.alt : '0;
      // an update match overwrites the alternate with the query symbol
      result.last_alt = (rule_free || rule_sym) ? entry.alt : key_sym;
   end

endmodule
